@@ sv/quaternion_yaw_extract_core_macros.svh @@
// Assertion macros for the quaternion yaw extractor checker.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef QUATERNION_YAW_EXTRACT_CORE_MACROS_SVH
`define QUATERNION_YAW_EXTRACT_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define QYE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qye_checker: same-cycle property violated");

// next-cycle implication, disabled in reset
`define QYE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qye_checker: next-cycle property violated");

`endif

@@ sv/qye_pkg.sv @@
// Shared types, constants and the arctangent table of the quaternion yaw extractor.
// No dependencies; every other .sv file imports this package.
`default_nettype none

package qye_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int ANGLE_STEPS_DEF     = 16;

	localparam int Q_W      = 32;
	localparam int T_W      = 34;
	localparam int XY_W     = 56;
	localparam int Z_W      = 36;
	localparam int ATAN_W   = 30;
	localparam int YAW_W    = 16;
	localparam int FLOOR_W  = 32;
	localparam int PRESCALE = 20;

	localparam int YAW_LIMIT   = 25736;
	localparam int ROUND_SHIFT = 17;

	localparam logic [FLOOR_W-1:0]    FLOOR_RESET = 32'd1;
	localparam logic signed [Z_W-1:0] PI_UNITS    = 36'sd3373259426;
	localparam logic signed [Z_W-1:0] ROUND_BIAS  = 36'sd65536;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [T_W-1:0] t1;
		logic signed [T_W-1:0] t2;
		logic                  fresh;
	} qye_job_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_FINISH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROTATE,
		BK_ROUND,
		BK_EMIT
	} back_state_t;

	function automatic logic [ATAN_W-1:0] atan_units(input logic [4:0] idx);
		logic [ATAN_W-1:0] a;
		case (idx)
			5'd0:    a = 30'd843314857;
			5'd1:    a = 30'd497837829;
			5'd2:    a = 30'd263043837;
			5'd3:    a = 30'd133525159;
			5'd4:    a = 30'd67021687;
			5'd5:    a = 30'd33543516;
			5'd6:    a = 30'd16775851;
			5'd7:    a = 30'd8388437;
			5'd8:    a = 30'd4194283;
			5'd9:    a = 30'd2097149;
			5'd10:   a = 30'd1048576;
			5'd11:   a = 30'd524288;
			5'd12:   a = 30'd262144;
			5'd13:   a = 30'd131072;
			5'd14:   a = 30'd65536;
			5'd15:   a = 30'd32768;
			5'd16:   a = 30'd16384;
			5'd17:   a = 30'd8192;
			5'd18:   a = 30'd4096;
			5'd19:   a = 30'd2048;
			5'd20:   a = 30'd1024;
			5'd21:   a = 30'd512;
			5'd22:   a = 30'd256;
			5'd23:   a = 30'd128;
			5'd24:   a = 30'd64;
			5'd25:   a = 30'd32;
			5'd26:   a = 30'd16;
			5'd27:   a = 30'd8;
			5'd28:   a = 30'd4;
			5'd29:   a = 30'd2;
			5'd30:   a = 30'd1;
			5'd31:   a = 30'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

@@ sv/quaternion_yaw_extract_core.sv @@
// Top level of the quaternion yaw extractor: front end, job queue and CORDIC back end.
// Depends on qye_pkg, qye_front, qye_queue and qye_back.
//
// Takes one quaternion transaction and returns one yaw transaction, in order.
// The front end holds in_stall from each accept until its job is queued: one
// shared multiplier forms six products in FR_MUL, then FR_FINISH classifies the
// item against norm_floor, so it takes no new transaction before the last is queued.
// The back end takes a fresh yaw through ANGLE_STEPS CORDIC rotation steps,
// one step per cycle, then rounds it in BK_ROUND and passes it to BK_EMIT; a
// held or zero-vector result goes straight to BK_EMIT. Either way it takes no
// new job until the last one is emitted.
// A two-entry queue and an output register let either side stall alone.
// norm_floor resets to 1 and may be written only while the block is idle.
`default_nettype none

module quaternion_yaw_extract_core #(
	parameter int COMPONENT_WIDTH = qye_pkg::COMPONENT_WIDTH_DEF,
	parameter int ANGLE_STEPS     = qye_pkg::ANGLE_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              norm_floor_we,
	input  logic [qye_pkg::FLOOR_W-1:0]       norm_floor_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_w,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_x,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_y,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_z,
	input  logic                              comps_valid,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [qye_pkg::YAW_W-1:0]  yaw_angle,
	output logic                              yaw_held
);
	import qye_pkg::*;

	qye_job_t front_job, back_job;
	logic     front_valid, front_stall;
	logic     back_valid, back_stall;

	qye_front #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.norm_floor_we    (norm_floor_we),
		.norm_floor_wdata (norm_floor_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.comp_w           (comp_w),
		.comp_x           (comp_x),
		.comp_y           (comp_y),
		.comp_z           (comp_z),
		.comps_valid      (comps_valid),
		.job_valid        (front_valid),
		.job_stall        (front_stall),
		.job              (front_job)
	);

	qye_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_stall (front_stall),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_stall  (back_stall),
		.pop_job    (back_job)
	);

	qye_back #(
		.ANGLE_STEPS(ANGLE_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_stall (back_stall),
		.job       (back_job),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.yaw_angle (yaw_angle),
		.yaw_held  (yaw_held)
	);

endmodule

`default_nettype wire

@@ sv/qye_front.sv @@
// Front end: accepts quaternions, forms the six scaled products on one shared
// multiplier, classifies the item against norm_floor and queues a job. Uses qye_pkg.
`default_nettype none

module qye_front #(
	parameter int COMPONENT_WIDTH = qye_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              norm_floor_we,
	input  logic [qye_pkg::FLOOR_W-1:0]       norm_floor_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_w,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_x,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_y,
	input  logic signed [COMPONENT_WIDTH-1:0] comp_z,
	input  logic                              comps_valid,
	output logic                              job_valid,
	input  logic                              job_stall,
	output qye_pkg::qye_job_t                 job
);
	import qye_pkg::*;

	localparam int PW = 2 * COMPONENT_WIDTH;

	localparam logic [2:0] TERM_WW   = 3'd0;
	localparam logic [2:0] TERM_XX   = 3'd1;
	localparam logic [2:0] TERM_YY   = 3'd2;
	localparam logic [2:0] TERM_ZZ   = 3'd3;
	localparam logic [2:0] TERM_WZ   = 3'd4;
	localparam logic [2:0] TERM_XY   = 3'd5;
	localparam logic [2:0] TERM_LAST = 3'd6;

	front_state_t state_q, state_d;

	logic [FLOOR_W-1:0]               norm_floor_q;
	logic signed [COMPONENT_WIDTH-1:0] w_q, x_q, y_q, z_q;
	logic                             valid_q;
	logic [2:0]                       cnt_q;
	logic [2:0]                       prev_term;
	logic signed [COMPONENT_WIDTH-1:0] mul_a, mul_b;
	logic signed [PW-1:0]             prod_s1;
	logic signed [Q_W-1:0]            scaled;
	logic signed [T_W-1:0]            scaled_ext;
	logic signed [T_W-1:0]            norm_q, yz_q, cross_q;
	logic                             accept;

	generate
		if (COMPONENT_WIDTH >= 16) begin : g_shr
			logic signed [PW-1:0] shr;
			assign shr    = prod_s1 >>> (PW - 30);
			assign scaled = shr[Q_W-1:0];
		end else begin : g_shl
			logic signed [Q_W-1:0] ext;
			assign ext    = {{(Q_W-PW){prod_s1[PW-1]}}, prod_s1};
			assign scaled = ext <<< (Q_W - PW);
		end
	endgenerate

	assign scaled_ext = {{(T_W-Q_W){scaled[Q_W-1]}}, scaled};
	assign prev_term  = cnt_q - 3'd1;
	assign in_stall   = (state_q != FR_IDLE);
	assign accept     = in_valid && !in_stall;

	assign job_valid = (state_q == FR_FINISH);
	assign job.t1    = cross_q <<< 1;
	assign job.t2    = norm_q - (yz_q <<< 1);
	assign job.fresh = valid_q && (norm_q >= $signed({{(T_W-FLOOR_W){1'b0}}, norm_floor_q}));

	always_comb begin
		case (cnt_q)
			TERM_WW: begin mul_a = w_q; mul_b = w_q; end
			TERM_XX: begin mul_a = x_q; mul_b = x_q; end
			TERM_YY: begin mul_a = y_q; mul_b = y_q; end
			TERM_ZZ: begin mul_a = z_q; mul_b = z_q; end
			TERM_WZ: begin mul_a = w_q; mul_b = z_q; end
			TERM_XY: begin mul_a = x_q; mul_b = y_q; end
			default: begin mul_a = '0;  mul_b = '0;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (accept) state_d = FR_MUL;
			end
			FR_MUL: begin
				if (cnt_q == TERM_LAST) state_d = FR_FINISH;
			end
			FR_FINISH: begin
				if (!job_stall) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_floor_q <= FLOOR_RESET;
		end else if (norm_floor_we) begin
			norm_floor_q <= norm_floor_wdata;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (accept) begin
			w_q     <= comp_w;
			x_q     <= comp_x;
			y_q     <= comp_y;
			z_q     <= comp_z;
			valid_q <= comps_valid;
			cnt_q   <= '0;
			norm_q  <= '0;
			yz_q    <= '0;
			cross_q <= '0;
		end else if (state_q == FR_MUL) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q != TERM_WW) begin
				if (prev_term inside {TERM_WW, TERM_XX, TERM_YY, TERM_ZZ})
					norm_q <= norm_q + scaled_ext;
				if (prev_term inside {TERM_YY, TERM_ZZ})
					yz_q <= yz_q + scaled_ext;
				if (prev_term inside {TERM_WZ, TERM_XY})
					cross_q <= cross_q + scaled_ext;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/qye_queue.sv @@
// Short job queue between front and back end of the yaw extractor.
// Uses qye_pkg for the job type and depth.
`default_nettype none

module qye_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_stall,
	input  qye_pkg::qye_job_t push_job,
	output logic              pop_valid,
	input  logic              pop_stall,
	output qye_pkg::qye_job_t pop_job
);
	import qye_pkg::*;

	qye_job_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push, pop;

	assign push_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_job    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

@@ sv/qye_back.sv @@
// Back end: iterative CORDIC atan2 over queued jobs, held-yaw register and
// the output register. Uses qye_pkg for types, constants and the arctangent table.
`default_nettype none

module qye_back #(
	parameter int ANGLE_STEPS = qye_pkg::ANGLE_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	output logic                            job_stall,
	input  qye_pkg::qye_job_t               job,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [qye_pkg::YAW_W-1:0] yaw_angle,
	output logic                            yaw_held
);
	import qye_pkg::*;

	localparam int SW   = $clog2(ANGLE_STEPS);
	localparam int RW   = Z_W - ROUND_SHIFT;
	localparam logic signed [RW-1:0] LIM_P = RW'(YAW_LIMIT);
	localparam logic signed [RW-1:0] LIM_N = -LIM_P;

	back_state_t state_q, state_d;

	logic signed [XY_W-1:0]  x_q, y_q, xs, ys, x0, y0;
	logic signed [Z_W-1:0]   z_q, step_atan, z_rnd;
	logic [SW-1:0]           step_q;
	logic signed [RW-1:0]    rnd;
	logic signed [YAW_W-1:0] sat;
	logic signed [YAW_W-1:0] res_yaw_q, held_yaw_q, yaw_q;
	logic                    res_held_q, held_q, out_valid_q;
	logic                    take, zero_vec, last_step, emit;

	assign job_stall = (state_q != BK_IDLE);
	assign take      = job_valid && !job_stall;
	assign zero_vec  = (job.t1 == '0) && (job.t2 == '0);
	assign last_step = (step_q == SW'(ANGLE_STEPS - 1));
	assign emit      = (state_q == BK_EMIT) && (!out_valid_q || !out_stall);

	assign x0 = {{(XY_W-T_W-PRESCALE){job.t2[T_W-1]}}, job.t2, {PRESCALE{1'b0}}};
	assign y0 = {{(XY_W-T_W-PRESCALE){job.t1[T_W-1]}}, job.t1, {PRESCALE{1'b0}}};

	assign xs        = x_q >>> step_q;
	assign ys        = y_q >>> step_q;
	assign step_atan = {{(Z_W-ATAN_W){1'b0}}, atan_units(5'(step_q))};

	assign z_rnd = z_q + ROUND_BIAS;
	assign rnd   = z_rnd[Z_W-1:ROUND_SHIFT];
	assign sat   = (rnd > LIM_P) ? LIM_P[YAW_W-1:0] :
	               (rnd < LIM_N) ? LIM_N[YAW_W-1:0] : rnd[YAW_W-1:0];

	assign out_valid = out_valid_q;
	assign yaw_angle = yaw_q;
	assign yaw_held  = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take) state_d = (!job.fresh || zero_vec) ? BK_EMIT : BK_ROTATE;
			end
			BK_ROTATE: begin
				if (last_step) state_d = BK_ROUND;
			end
			BK_ROUND: state_d = BK_EMIT;
			BK_EMIT: begin
				if (emit) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					res_held_q <= !job.fresh;
					res_yaw_q  <= job.fresh ? '0 : held_yaw_q;
					step_q     <= '0;
					if (job.t2 < 0) begin
						x_q <= -x0;
						y_q <= -y0;
						z_q <= (job.t1 >= 0) ? PI_UNITS : -PI_UNITS;
					end else begin
						x_q <= x0;
						y_q <= y0;
						z_q <= '0;
					end
				end
			end
			BK_ROTATE: begin
				step_q <= step_q + 1'b1;
				if (y_q < 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - step_atan;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + step_atan;
				end
			end
			BK_ROUND: begin
				res_yaw_q  <= sat;
				res_held_q <= 1'b0;
			end
			default: ;
		endcase
		if (emit) begin
			yaw_q  <= res_yaw_q;
			held_q <= res_held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_yaw_q  <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (emit && !res_held_q)
				held_yaw_q <= res_yaw_q;
		end
	end

endmodule

`default_nettype wire

@@ sv/qye_checker.sv @@
// Port-level checker for the quaternion yaw extractor, bound to the top level.
// Uses qye_pkg and the assertion macros header.
`default_nettype none

`include "quaternion_yaw_extract_core_macros.svh"

module qye_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [qye_pkg::YAW_W-1:0] yaw_angle,
	input logic                             yaw_held
);
	import qye_pkg::*;

	logic signed [YAW_W-1:0] last_yaw_q;
	logic [YAW_W:0]          out_word;
	logic                    yaw_in_range;

	assign out_word     = {yaw_held, yaw_angle};
	assign yaw_in_range = (yaw_angle <= YAW_W'(YAW_LIMIT)) &&
	                      (yaw_angle >= -YAW_W'(YAW_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_yaw_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_yaw_q <= yaw_angle;
		end
	end

	`QYE_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid)
	`QYE_ASSERT_NEXT(a_out_payload_holds, out_valid && out_stall, $stable(out_word))
	`QYE_ASSERT_NOW(a_yaw_in_range, out_valid, yaw_in_range)
	`QYE_ASSERT_NOW(a_held_repeats_last, out_valid && yaw_held, yaw_angle == last_yaw_q)
	`QYE_ASSERT_NEXT(a_front_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind quaternion_yaw_extract_core qye_checker u_qye_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.yaw_angle (yaw_angle),
	.yaw_held  (yaw_held)
);

`default_nettype wire
